[hdl/pfcq_pkg.sv]
// ----------------------------------------------------------------------------
// pfcq_pkg
// Shared types and constants of the egress port queue with pause handling
// and congestion marking.
// ----------------------------------------------------------------------------
package pfcq_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [23:0] BYTES_MAX = 24'hFF_FFFF;

    localparam logic [1:0] CFG_IDX_ECN_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_IDX_ECN_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_IDX_MAX_BYTES     = 2'd2;

    typedef logic [FIFO_AW-1:0] t_fifo_idx;
    typedef logic [FIFO_CW-1:0] t_fifo_cnt;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_PAUSE   = 2'd1,
        ACT_RESUME  = 2'd2,
        ACT_TX_DONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        SEND_READY      = 2'd0,
        SEND_PAUSE_RCVD = 2'd1,
        SEND_PAUSED     = 2'd2
    } t_send_state;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_READ = 1'b1
    } t_seq_state;

    typedef struct packed {
        logic [15:0] tag;
        logic [13:0] bytes;
        logic        eligible;
        logic        int_request;
        logic [5:0]  port;
    } t_desc;

    typedef struct packed {
        logic        start_valid;
        logic [15:0] start_tag;
        logic [13:0] start_bytes;
        logic        depart_valid;
        logic [15:0] depart_tag;
        logic [5:0]  depart_port;
        logic        ecn_mark;
        logic        int_valid;
        logic [23:0] int_queue_bytes;
        logic [47:0] int_tx_bytes;
        logic        over_limit;
        logic        refused;
    } t_result;

    typedef struct packed {
        logic        ecn_enable;
        logic [23:0] ecn_threshold_bytes;
        logic [23:0] max_queue_bytes;
    } t_cfg;

    typedef struct packed {
        logic      we;
        t_fifo_idx waddr;
        t_desc     wdata;
        logic      re;
        t_fifo_idx raddr;
    } t_ram_req;

endpackage

[hdl/pfcq_ifs.sv]
// ----------------------------------------------------------------------------
// pfcq_ifs
// Handshake channels of the egress queue: event input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface pfcq_in_if;
    import pfcq_pkg::*;

    logic        valid;
    logic        ready;
    t_action     action;
    logic [15:0] pkt_tag;
    logic [13:0] pkt_bytes;
    logic        ecn_eligible;
    logic        int_request;
    logic [5:0]  ingress_port;

    modport source (output valid, action, pkt_tag, pkt_bytes, ecn_eligible,
                    int_request, ingress_port, input ready);
    modport sink (input valid, action, pkt_tag, pkt_bytes, ecn_eligible,
                  int_request, ingress_port, output ready);
endinterface

interface pfcq_out_if;
    logic        valid;
    logic        ready;
    logic        start_valid;
    logic [15:0] start_tag;
    logic [13:0] start_bytes;
    logic        depart_valid;
    logic [15:0] depart_tag;
    logic [5:0]  depart_port;
    logic        ecn_mark;
    logic        int_valid;
    logic [23:0] int_queue_bytes;
    logic [47:0] int_tx_bytes;
    logic        over_limit;
    logic        refused;

    modport source (output valid, start_valid, start_tag, start_bytes, depart_valid,
                    depart_tag, depart_port, ecn_mark, int_valid, int_queue_bytes,
                    int_tx_bytes, over_limit, refused, input ready);
    modport sink (input valid, start_valid, start_tag, start_bytes, depart_valid,
                  depart_tag, depart_port, ecn_mark, int_valid, int_queue_bytes,
                  int_tx_bytes, over_limit, refused, output ready);
endinterface

interface pfcq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/pfcq_desc_ram.sv]
// ----------------------------------------------------------------------------
// pfcq_desc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfcq_desc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 38
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/pfcq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pfcq_cfg_regs
// Configuration register file: marking enable, marking threshold and the
// occupancy limit.
// ----------------------------------------------------------------------------
module pfcq_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfcq_cfg_if.sink      i_cfg,
    output pfcq_pkg::t_cfg o_cfg
);
    import pfcq_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IDX_ECN_ENABLE:    n_cfg.ecn_enable          = i_cfg.data[0];
                CFG_IDX_ECN_THRESHOLD: n_cfg.ecn_threshold_bytes = i_cfg.data;
                CFG_IDX_MAX_BYTES:     n_cfg.max_queue_bytes     = i_cfg.data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ecn_enable          <= 1'b0;
            r_cfg.ecn_threshold_bytes <= '0;
            r_cfg.max_queue_bytes     <= BYTES_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

[hdl/pfcq_ctrl.sv]
// ----------------------------------------------------------------------------
// pfcq_ctrl
// Queue controller: FIFO pointers, occupancy and transmit counters, pause
// state, head descriptor register and the read sequencer of the RAM.
// ----------------------------------------------------------------------------
module pfcq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfcq_pkg::t_action  i_in_action,
    input  pfcq_pkg::t_desc    i_in_desc,
    input  pfcq_pkg::t_cfg     i_cfg,
    input  logic               i_slot_free,
    output logic               o_res_valid,
    output pfcq_pkg::t_result  o_res,
    output pfcq_pkg::t_ram_req o_ram_req,
    input  pfcq_pkg::t_desc    i_ram_rdata
);
    import pfcq_pkg::*;

    t_seq_state  r_seq,         n_seq;
    t_fifo_idx   r_head,        n_head;
    t_fifo_idx   r_tail,        n_tail;
    t_fifo_cnt   r_count,       n_count;
    t_send_state r_send_state,  n_send_state;
    logic        r_sending,     n_sending;
    logic [23:0] r_queue_bytes, n_queue_bytes;
    logic [47:0] r_tx_bytes,    n_tx_bytes;
    t_desc       r_head_desc,   n_head_desc;
    t_result     r_pend_res,    n_pend_res;
    logic        r_pend_start,  n_pend_start;

    logic        in_fire;
    t_fifo_idx   head_next;
    t_fifo_idx   tail_next;
    logic [24:0] enq_sum;
    t_send_state st_after;
    t_result     res;
    logic        res_valid;
    t_ram_req    ram_req;

    assign o_in_ready = (r_seq == SEQ_IDLE) && i_slot_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign head_next  = (r_head == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_head + FIFO_AW'(1);
    assign tail_next  = (r_tail == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_tail + FIFO_AW'(1);
    assign enq_sum    = {1'b0, r_queue_bytes} + 25'(i_in_desc.bytes);

    always_comb begin
        n_seq         = r_seq;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_send_state  = r_send_state;
        n_sending     = r_sending;
        n_queue_bytes = r_queue_bytes;
        n_tx_bytes    = r_tx_bytes;
        n_head_desc   = r_head_desc;
        n_pend_res    = r_pend_res;
        n_pend_start  = r_pend_start;
        st_after      = r_send_state;
        res           = '0;
        res_valid     = 1'b0;
        ram_req       = '0;
        ram_req.waddr = r_tail;
        ram_req.wdata = i_in_desc;
        ram_req.raddr = head_next;

        case (r_seq)
            SEQ_IDLE: begin
                if (in_fire) begin
                    res_valid = 1'b1;
                    case (i_in_action)
                        ACT_ENQUEUE: begin
                            if (r_count == FIFO_CW'(FIFO_DEPTH)) begin
                                res.refused = 1'b1;
                            end else begin
                                ram_req.we    = 1'b1;
                                n_tail        = tail_next;
                                n_count       = r_count + FIFO_CW'(1);
                                n_queue_bytes = enq_sum[24] ? BYTES_MAX : enq_sum[23:0];
                                res.over_limit = (n_queue_bytes > i_cfg.max_queue_bytes);
                                // An empty queue gets its head straight from the input.
                                if (r_count == '0) begin
                                    n_head_desc = i_in_desc;
                                    if (r_send_state == SEND_READY && !r_sending) begin
                                        n_sending       = 1'b1;
                                        res.start_valid = 1'b1;
                                        res.start_tag   = i_in_desc.tag;
                                        res.start_bytes = i_in_desc.bytes;
                                    end
                                end
                            end
                        end
                        ACT_PAUSE: begin
                            n_send_state = r_sending ? SEND_PAUSE_RCVD : SEND_PAUSED;
                        end
                        ACT_RESUME: begin
                            n_send_state = SEND_READY;
                            if (r_count != '0 && !r_sending) begin
                                n_sending       = 1'b1;
                                res.start_valid = 1'b1;
                                res.start_tag   = r_head_desc.tag;
                                res.start_bytes = r_head_desc.bytes;
                            end
                        end
                        ACT_TX_DONE: begin
                            n_sending = 1'b0;
                            if (r_sending && r_count != '0) begin
                                res.depart_valid = 1'b1;
                                res.depart_tag   = r_head_desc.tag;
                                res.depart_port  = r_head_desc.port;
                                res.ecn_mark     = i_cfg.ecn_enable
                                                   && (r_queue_bytes > i_cfg.ecn_threshold_bytes)
                                                   && r_head_desc.eligible;
                                if (r_head_desc.int_request) begin
                                    res.int_valid       = 1'b1;
                                    res.int_queue_bytes = r_queue_bytes;
                                    res.int_tx_bytes    = r_tx_bytes;
                                end
                                n_queue_bytes = (r_queue_bytes > 24'(r_head_desc.bytes))
                                              ? r_queue_bytes - 24'(r_head_desc.bytes) : '0;
                                n_tx_bytes    = r_tx_bytes + 48'(r_head_desc.bytes);
                                n_head        = head_next;
                                n_count       = r_count - FIFO_CW'(1);
                                if (r_send_state == SEND_PAUSE_RCVD) begin
                                    st_after = SEND_PAUSED;
                                end
                                n_send_state = st_after;
                                // Packets remain: fetch the new head, finish next cycle.
                                if (r_count > FIFO_CW'(1)) begin
                                    ram_req.re   = 1'b1;
                                    res_valid    = 1'b0;
                                    n_seq        = SEQ_READ;
                                    n_pend_res   = res;
                                    n_pend_start = (st_after == SEND_READY);
                                    n_sending    = (st_after == SEND_READY);
                                end
                            end
                        end
                        default: begin
                            res = '0;
                        end
                    endcase
                end
            end
            SEQ_READ: begin
                res_valid   = 1'b1;
                res         = r_pend_res;
                n_head_desc = i_ram_rdata;
                n_seq       = SEQ_IDLE;
                if (r_pend_start) begin
                    res.start_valid = 1'b1;
                    res.start_tag   = i_ram_rdata.tag;
                    res.start_bytes = i_ram_rdata.bytes;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SEQ_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_send_state  <= SEND_READY;
            r_sending     <= 1'b0;
            r_queue_bytes <= '0;
            r_tx_bytes    <= '0;
        end else begin
            r_seq         <= n_seq;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_send_state  <= n_send_state;
            r_sending     <= n_sending;
            r_queue_bytes <= n_queue_bytes;
            r_tx_bytes    <= n_tx_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_desc  <= n_head_desc;
        r_pend_res   <= n_pend_res;
        r_pend_start <= n_pend_start;
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;
    assign o_ram_req   = ram_req;
endmodule

[hdl/pfc_egress_queue_ecn_marker_core.sv]
// ----------------------------------------------------------------------------
// pfc_egress_queue_ecn_marker_core
// Egress port queue of a lossless switch with pause handling and ECN marking.
// ----------------------------------------------------------------------------
// Events enter on i_in (enqueue, pause frame, resume frame, transmit done),
// one transaction per event, and each event yields exactly one result
// transaction on o_out. i_cfg writes the marking enable, the marking threshold
// and the occupancy limit; it is always ready and should only be used while
// no event is in progress.
// Descriptors are kept in a 64-entry RAM; the head descriptor is also held in
// a register, so most events finish in the cycle they are accepted and their
// result is registered and appears in the next cycle, at one event per cycle
// while o_out is not stalled. A transmit done that leaves packets queued
// reads the new head from the RAM; its result is formed in the read state
// that follows, and i_in is held off in that state.
// A result waiting in the output register does not block the next event as
// long as o_out.ready drains it in the same cycle; while the receiver stalls,
// i_in is held off. Reset empties the queue, clears the counters, sets the
// port ready and restores the register defaults; the descriptor RAM itself is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pfc_egress_queue_ecn_marker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfcq_in_if.sink     i_in,
    pfcq_out_if.source  o_out,
    pfcq_cfg_if.sink    i_cfg
);
    import pfcq_pkg::*;

    t_cfg     cfg;
    t_desc    in_desc;
    t_result  res;
    logic     res_valid;
    logic     slot_free;
    t_ram_req ram_req;
    t_desc    ram_rdata;

    logic     r_out_valid, n_out_valid;
    t_result  r_out;

    assign in_desc.tag         = i_in.pkt_tag;
    assign in_desc.bytes       = i_in.pkt_bytes;
    assign in_desc.eligible    = i_in.ecn_eligible;
    assign in_desc.int_request = i_in.int_request;
    assign in_desc.port        = i_in.ingress_port;

    assign slot_free = !r_out_valid || o_out.ready;

    pfcq_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pfcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_action (i_in.action),
        .i_in_desc   (in_desc),
        .i_cfg       (cfg),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    pfcq_desc_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH ($bits(t_desc))
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.start_valid     = r_out.start_valid;
    assign o_out.start_tag       = r_out.start_tag;
    assign o_out.start_bytes     = r_out.start_bytes;
    assign o_out.depart_valid    = r_out.depart_valid;
    assign o_out.depart_tag      = r_out.depart_tag;
    assign o_out.depart_port     = r_out.depart_port;
    assign o_out.ecn_mark        = r_out.ecn_mark;
    assign o_out.int_valid       = r_out.int_valid;
    assign o_out.int_queue_bytes = r_out.int_queue_bytes;
    assign o_out.int_tx_bytes    = r_out.int_tx_bytes;
    assign o_out.over_limit      = r_out.over_limit;
    assign o_out.refused         = r_out.refused;
endmodule

[hdl/pfcq_checker.sv]
// ----------------------------------------------------------------------------
// pfcq_checker
// Port-level checks of the egress queue result channel, bound to the core.
// ----------------------------------------------------------------------------
module pfcq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_start_valid,
    input logic        i_depart_valid,
    input logic        i_ecn_mark,
    input logic        i_int_valid,
    input logic [23:0] i_int_queue_bytes,
    input logic [47:0] i_int_tx_bytes,
    input logic        i_over_limit,
    input logic        i_refused
);
    // A refused enqueue changes nothing, so it reports nothing else.
    a_refused_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_refused) |-> (!i_start_valid && !i_depart_valid && !i_over_limit))
        else $error("refused result carries other flags");

    // Marking and telemetry only accompany a departure.
    a_mark_on_depart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_ecn_mark || i_int_valid)) |-> i_depart_valid)
        else $error("mark or telemetry without departure");

    a_int_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_int_valid) |-> (i_int_queue_bytes == '0 && i_int_tx_bytes == '0))
        else $error("telemetry values present without telemetry request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_depart_valid) && $stable(i_start_valid)
             && $stable(i_int_tx_bytes)))
        else $error("stalled result changed");
endmodule

bind pfc_egress_queue_ecn_marker_core pfcq_checker u_pfcq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_start_valid     (o_out.start_valid),
    .i_depart_valid    (o_out.depart_valid),
    .i_ecn_mark        (o_out.ecn_mark),
    .i_int_valid       (o_out.int_valid),
    .i_int_queue_bytes (o_out.int_queue_bytes),
    .i_int_tx_bytes    (o_out.int_tx_bytes),
    .i_over_limit      (o_out.over_limit),
    .i_refused         (o_out.refused)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lossless egress queue with pause handling and
// ECN marking. Outside the back-to-back test, events are driven on the input
// channel with random gaps and the result channel is stalled at random. An
// in-bench model of the queue predicts one result per accepted event, and
// each received result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import pfcq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_SLACK    = 4;

    logic i_clk;
    logic i_rst_n;

    pfcq_in_if  in_ch ();
    pfcq_out_if out_ch ();
    pfcq_cfg_if cfg_ch ();

    pfc_egress_queue_ecn_marker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Queue model state and register shadow.
    t_desc       desc_ring [FIFO_DEPTH];
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned ring_count;
    t_send_state port_state;
    bit          in_flight;
    logic [23:0] occ_bytes;
    logic [47:0] sent_bytes;
    t_cfg        cfg_shadow;

    t_result expected_results [$];

    int  errors;
    int  n_events;
    int  n_results;
    int  n_starts;
    int  n_departs;
    int  n_marks;
    int  n_refused;
    int  n_over;
    int  n_reg_writes;
    int  n_settings;
    int  idle_cycles;
    int  out_stall_left;
    bit  gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Model of the queue
    // ------------------------------------------------------------------
    function automatic void launch_head(inout t_result r);
        in_flight     = 1'b1;
        r.start_valid = 1'b1;
        r.start_tag   = desc_ring[ring_head].tag;
        r.start_bytes = desc_ring[ring_head].bytes;
    endfunction

    function automatic t_result next_queue_result(t_action act, t_desc pkt);
        t_result     r;
        logic [24:0] sum;
        t_desc       h;
        bit          was_empty;
        r = '0;
        case (act)
            ACT_ENQUEUE: begin
                if (ring_count >= FIFO_DEPTH) begin
                    r.refused = 1'b1;
                end else begin
                    was_empty = (ring_count == 0);
                    desc_ring[ring_tail] = pkt;
                    ring_tail = (ring_tail + 1) % FIFO_DEPTH;
                    ring_count++;
                    sum = {1'b0, occ_bytes} + 25'(pkt.bytes);
                    occ_bytes = (sum > BYTES_MAX) ? BYTES_MAX : sum[23:0];
                    r.over_limit = (occ_bytes > cfg_shadow.max_queue_bytes);
                    if (was_empty && port_state == SEND_READY && !in_flight) begin
                        launch_head(r);
                    end
                end
            end
            ACT_PAUSE: begin
                port_state = in_flight ? SEND_PAUSE_RCVD : SEND_PAUSED;
            end
            ACT_RESUME: begin
                port_state = SEND_READY;
                if (ring_count > 0 && !in_flight) begin
                    launch_head(r);
                end
            end
            default: begin
                if (!in_flight || ring_count == 0) begin
                    in_flight = 1'b0;
                end else begin
                    h = desc_ring[ring_head];
                    r.depart_valid = 1'b1;
                    r.depart_tag   = h.tag;
                    r.depart_port  = h.port;
                    r.ecn_mark     = cfg_shadow.ecn_enable && h.eligible &&
                                     (occ_bytes > cfg_shadow.ecn_threshold_bytes);
                    if (h.int_request) begin
                        r.int_valid       = 1'b1;
                        r.int_queue_bytes = occ_bytes;
                        r.int_tx_bytes    = sent_bytes;
                    end
                    occ_bytes  = (occ_bytes > 24'(h.bytes)) ? occ_bytes - 24'(h.bytes) : '0;
                    sent_bytes = sent_bytes + 48'(h.bytes);
                    ring_head  = (ring_head + 1) % FIFO_DEPTH;
                    ring_count--;
                    in_flight  = 1'b0;
                    if (port_state == SEND_PAUSE_RCVD) begin
                        port_state = SEND_PAUSED;
                    end
                    if (ring_count > 0 && port_state == SEND_READY) begin
                        launch_head(r);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic t_desc make_pkt(logic [15:0] tag, logic [13:0] nbytes,
                                       logic elig, logic intr, logic [5:0] port);
        t_desc d;
        d.tag         = tag;
        d.bytes       = nbytes;
        d.eligible    = elig;
        d.int_request = intr;
        d.port        = port;
        return d;
    endfunction

    function automatic t_desc random_pkt();
        int    r;
        t_desc d;
        r = $urandom_range(0, 99);
        d = make_pkt(16'($urandom), 14'($urandom), 1'($urandom), 1'($urandom),
                     6'($urandom));
        if (r < 8) d.bytes = '0;
        else if (r < 16) d.bytes = 14'h3FFF;
        else if (r < 50) d.bytes = 14'($urandom_range(1, 2000));
        return d;
    endfunction

    task automatic send_event(t_action act, t_desc pkt);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.pkt_tag      <= pkt.tag;
        in_ch.pkt_bytes    <= pkt.bytes;
        in_ch.ecn_eligible <= pkt.eligible;
        in_ch.int_request  <= pkt.int_request;
        in_ch.ingress_port <= pkt.port;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_results.push_back(next_queue_result(act, pkt));
        n_events++;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    // Sender holds off until every predicted result has been received.
    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Callers leave the input channel idle before changing the registers.
    task automatic apply_config(logic en, logic [23:0] thr, logic [23:0] max_bytes);
        logic [1:0]  idx [3];
        logic [23:0] val [3];
        idx = '{CFG_IDX_ECN_ENABLE, CFG_IDX_ECN_THRESHOLD, CFG_IDX_MAX_BYTES};
        val = '{{23'd0, en}, thr, max_bytes};
        wait_drained();
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (idx[i])
                CFG_IDX_ECN_ENABLE:    cfg_shadow.ecn_enable = val[i][0];
                CFG_IDX_ECN_THRESHOLD: cfg_shadow.ecn_threshold_bytes = val[i];
                default:               cfg_shadow.max_queue_bytes = val[i];
            endcase
            n_reg_writes++;
        end
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // Random event mix; control frames are rare so the port keeps serving.
    task automatic run_traffic(int n, int enq_pct, int ctl_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 || $urandom_range(0, 99) == 0) begin
                release_input();
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < enq_pct) begin
                send_event(ACT_ENQUEUE, random_pkt());
            end else if (r < enq_pct + ctl_pct) begin
                send_event(($urandom_range(0, 99) < 40) ? ACT_PAUSE : ACT_RESUME,
                           random_pkt());
            end else begin
                send_event(ACT_TX_DONE, random_pkt());
            end
        end
        release_input();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        t_desc nul;
        nul = make_pkt('0, '0, 1'b0, 1'b0, '0);
        apply_config(1'b1, 24'd0, 24'd0);
        send_event(ACT_TX_DONE, make_pkt(16'hFFFF, 14'h3FFF, 1'b1, 1'b1, 6'h3F));
        send_event(ACT_PAUSE, nul);
        send_event(ACT_PAUSE, nul);
        send_event(ACT_ENQUEUE, make_pkt(16'hFFFF, 14'h3FFF, 1'b1, 1'b1, 6'h3F));
        send_event(ACT_ENQUEUE, nul);
        send_event(ACT_TX_DONE, nul);
        send_event(ACT_RESUME, nul);
        // Pause frames while a packet is on the wire, a resume and one more pause,
        // so the packet in flight finishes and leaves the port paused.
        send_event(ACT_PAUSE, nul);
        send_event(ACT_PAUSE, nul);
        send_event(ACT_RESUME, nul);
        send_event(ACT_PAUSE, nul);
        send_event(ACT_TX_DONE, nul);
        send_event(ACT_RESUME, nul);
        send_event(ACT_TX_DONE, nul);
        send_event(ACT_TX_DONE, nul);
        send_event(ACT_ENQUEUE, make_pkt(16'h8001, 14'd0, 1'b1, 1'b1, 6'd0));
        send_event(ACT_ENQUEUE, make_pkt(16'h1234, 14'd1, 1'b1, 1'b1, 6'd5));
        send_event(ACT_TX_DONE, nul);
        send_event(ACT_TX_DONE, nul);
        send_event(ACT_RESUME, nul);
        release_input();
    endtask

    task automatic test_fifo_full();
        t_desc nul;
        nul = make_pkt('0, '0, 1'b0, 1'b0, '0);
        apply_config(1'b1, BYTES_MAX, BYTES_MAX);
        send_event(ACT_PAUSE, nul);
        for (int i = 0; i < FIFO_DEPTH + 2; i++) begin
            send_event(ACT_ENQUEUE, random_pkt());
        end
        send_event(ACT_RESUME, nul);
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            send_event(ACT_TX_DONE, random_pkt());
        end
        release_input();
    endtask

    task automatic test_mixed_traffic();
        apply_config(1'b1, 24'd40000, 24'd60000);
        run_traffic(250, 55, 8);
        apply_config(1'b1, BYTES_MAX, 24'($urandom_range(0, 300000)));
        run_traffic(250, 50, 8);
    endtask

    task automatic test_back_to_back();
        apply_config(1'b1, 24'($urandom_range(0, 300000)), 24'($urandom_range(0, 300000)));
        gaps_on = 1'b0;
        run_traffic(300, 45, 8);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_heavy_load();
        // Marking off with a zero threshold: nothing may be marked.
        apply_config(1'b0, 24'd0, BYTES_MAX);
        run_traffic(300, 62, 4);
    endtask

    // ------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready   <= 1'b0;
        out_stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (out_stall_left > 0) begin
                out_ch.ready <= 1'b0;
                out_stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 99) < 30) out_stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            errors++;
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("[%0t] result transaction with nothing expected", $time);
            end else begin
                want = expected_results.pop_front();
                check_field("start_valid", 48'(want.start_valid), 48'(out_ch.start_valid));
                check_field("start_tag", 48'(want.start_tag), 48'(out_ch.start_tag));
                check_field("start_bytes", 48'(want.start_bytes), 48'(out_ch.start_bytes));
                check_field("depart_valid", 48'(want.depart_valid),
                            48'(out_ch.depart_valid));
                check_field("depart_tag", 48'(want.depart_tag), 48'(out_ch.depart_tag));
                check_field("depart_port", 48'(want.depart_port), 48'(out_ch.depart_port));
                check_field("ecn_mark", 48'(want.ecn_mark), 48'(out_ch.ecn_mark));
                check_field("int_valid", 48'(want.int_valid), 48'(out_ch.int_valid));
                check_field("int_queue_bytes", 48'(want.int_queue_bytes),
                            48'(out_ch.int_queue_bytes));
                check_field("int_tx_bytes", want.int_tx_bytes, out_ch.int_tx_bytes);
                check_field("over_limit", 48'(want.over_limit), 48'(out_ch.over_limit));
                check_field("refused", 48'(want.refused), 48'(out_ch.refused));
                n_starts  += int'(want.start_valid);
                n_departs += int'(want.depart_valid);
                n_marks   += int'(want.ecn_mark);
                n_refused += int'(want.refused);
                n_over    += int'(want.over_limit);
            end
        end
    end

    // Ends the run if no channel completes a transaction for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= ACT_ENQUEUE;
        in_ch.pkt_tag      <= '0;
        in_ch.pkt_bytes    <= '0;
        in_ch.ecn_eligible <= 1'b0;
        in_ch.int_request  <= 1'b0;
        in_ch.ingress_port <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_IDX_ECN_ENABLE;
        cfg_ch.data        <= '0;

        errors = 0; n_events = 0; n_results = 0; n_starts = 0; n_departs = 0;
        n_marks = 0; n_refused = 0; n_over = 0; n_reg_writes = 0; n_settings = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;

        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
        port_state = SEND_READY;
        in_flight  = 1'b0;
        occ_bytes  = '0;
        sent_bytes = '0;
        cfg_shadow.ecn_enable          = 1'b0;
        cfg_shadow.ecn_threshold_bytes = '0;
        cfg_shadow.max_queue_bytes     = BYTES_MAX;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fifo_full();
        test_mixed_traffic();
        test_back_to_back();
        test_heavy_load();

        wait_drained();
        $display("Covered %0d events and %0d results: %0d starts, %0d departures, %0d marked,",
                 n_events, n_results, n_starts, n_departs, n_marks);
        $display("%0d refused, %0d over limit, under %0d register settings (%0d writes).",
                 n_refused, n_over, n_settings, n_reg_writes);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
